// File: rtl/dhcp_lease_server_defines.svh
// Assertion macros for the DHCP lease server.
// Included by the top level; no other dependencies.
`ifndef DHCP_LEASE_SERVER_DEFINES_SVH
`define DHCP_LEASE_SERVER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define DLS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dhcp_lease_server: check failed");

// next-cycle implication, disabled in reset
`define DLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dhcp_lease_server: check failed");

`else

`define DLS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DLS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/dls_pkg.sv
// Shared constants for the DHCP lease server: register indexes, message
// codes, reply kinds, timing constants. No dependencies.
`timescale 1ns / 1ps

package dls_pkg;

    // pool geometry
    localparam int DEFAULT_POOL_SIZE = 8;

    // register reset values
    localparam logic [31:0] SRV_ADDR_RESET  = 32'hC0A8_0101;
    localparam logic [7:0]  POOL_BASE_RESET = 8'd16;

    // configuration register indexes
    localparam logic [1:0] CFG_SRV_ADDR  = 2'd0;
    localparam logic [1:0] CFG_NETMASK   = 2'd1;
    localparam logic [1:0] CFG_POOL_BASE = 2'd2;

    // option status codes
    localparam logic [1:0] STAT_ABSENT = 2'd0;
    localparam logic [1:0] STAT_GOOD   = 2'd1;

    // DHCP message types
    localparam logic [7:0] TYPE_DISCOVER = 8'd1;
    localparam logic [7:0] TYPE_REQUEST  = 8'd3;
    localparam logic [7:0] TYPE_DECLINE  = 8'd4;
    localparam logic [7:0] TYPE_RELEASE  = 8'd7;

    // reply kinds
    localparam logic [1:0] KIND_OFFER = 2'd0;
    localparam logic [1:0] KIND_ACK   = 2'd1;
    localparam logic [1:0] KIND_NAK   = 2'd2;

    // hold times in ms
    localparam logic [31:0] OFFER_HOLD_MS = 32'd60000;
    localparam logic [31:0] LEASE_HOLD_MS = 32'd86400000;

    // owner marking a declined address
    localparam logic [47:0] MAC_DECLINED = 48'hFFFF_FFFF_FFFF;

endpackage

// File: rtl/dhcp_lease_server.sv
// DHCP lease server top level: request checks, lease scan and allocation.
// Depends on dls_pkg, dls_ram and dhcp_lease_server_defines.svh.
//
//   channel   direction  handshake                  word
//   request   in         start, busy                one pre-parsed DHCP request
//   reply     out        reply_valid (strobe)       offer / ack / nak
//   config    in         cfg_valid, cfg_ready       register index + data
//
// A request stays busy through a check state, the lease scan (one slot per
// cycle through the single read port of the lease RAM) and an update state.
// Any reply strobe follows in the cycle after the update state. A dropped
// request is busy for the check state only. Reset clears the per-slot live
// bits at once, so no clearing pass is needed. The reply cannot be stalled.
`timescale 1ns / 1ps
`include "dhcp_lease_server_defines.svh"

module dhcp_lease_server #(
    parameter int POOL_SIZE = dls_pkg::DEFAULT_POOL_SIZE
) (
    input  logic        clk,
    input  logic        rst_n,
    // request
    input  logic        start,
    output logic        busy,
    input  logic        header_ok,
    input  logic [31:0] now_ms,
    input  logic [47:0] client_mac,
    input  logic [1:0]  type_status,
    input  logic [7:0]  type_value,
    input  logic [1:0]  server_id_status,
    input  logic [31:0] server_id,
    input  logic [1:0]  requested_status,
    input  logic [31:0] requested_addr,
    input  logic [31:0] client_addr,
    input  logic [31:0] transaction_id,
    // reply
    output logic        reply_valid,
    output logic [1:0]  reply_kind,
    output logic [31:0] reply_xid,
    output logic [47:0] reply_mac,
    output logic [31:0] your_addr,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    import dls_pkg::*;

    localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W = $clog2(POOL_SIZE + 1);
    localparam int ENT_W = 48 + 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_ACT
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [31:0] srv_addr_reg, srv_addr_next;
    logic [7:0]  pool_base_reg, pool_base_next;

    // latched request
    logic        header_ok_reg, header_ok_next;
    logic [31:0] now_reg, now_next;
    logic [47:0] mac_reg, mac_next;
    logic [1:0]  tstat_reg, tstat_next;
    logic [7:0]  tval_reg, tval_next;
    logic [1:0]  sstat_reg, sstat_next;
    logic [31:0] sid_reg, sid_next;
    logic [1:0]  rstat_reg, rstat_next;
    logic [31:0] raddr_reg, raddr_next;
    logic [31:0] caddr_reg, caddr_next;
    logic [31:0] xid_reg, xid_next;

    // scan bookkeeping
    logic [CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 eval_vld_reg, eval_vld_next;
    logic [IDX_W-1:0]     eval_idx_reg, eval_idx_next;
    logic                 slot_hit_reg, slot_hit_next;
    logic [IDX_W-1:0]     slot_idx_reg, slot_idx_next;
    logic                 free_hit_reg, free_hit_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic                 want_ok_reg, want_ok_next;
    logic [IDX_W-1:0]     wanted_idx_reg, wanted_idx_next;
    logic [POOL_SIZE-1:0] live_reg, live_next;

    // reply
    logic        reply_valid_reg, reply_valid_next;
    logic [1:0]  reply_kind_reg, reply_kind_next;
    logic [31:0] reply_xid_reg, reply_xid_next;
    logic [47:0] reply_mac_reg, reply_mac_next;
    logic [31:0] your_addr_reg, your_addr_next;

    // lease RAM: {owner, expiry}
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [ENT_W-1:0] ram_rdata;
    logic [47:0]      owner_q;
    logic [31:0]      expiry_q;

    // combinational helpers
    logic             drop;
    logic [31:0]      req_addr;
    logic [8:0]       want_diff;
    logic             want_init;
    logic [31:0]      age;
    logic             live_now;
    logic             live_after;
    logic             mine;
    logic [31:0]      expiry_new;
    logic [IDX_W-1:0] act_slot;
    logic [31:0]      act_addr;

    dls_ram #(
        .WIDTH (ENT_W),
        .DEPTH (POOL_SIZE),
        .ADDR_W(IDX_W)
    ) u_lease_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(scan_idx_reg[IDX_W-1:0]),
        .rdata(ram_rdata)
    );

    assign owner_q  = ram_rdata[ENT_W-1:32];
    assign expiry_q = ram_rdata[31:0];

    // request filter
    assign drop = !header_ok_reg || (mac_reg == 48'd0) || (tstat_reg != STAT_GOOD)
                  || (sstat_reg != STAT_ABSENT && sstat_reg != STAT_GOOD)
                  || (sstat_reg == STAT_GOOD && sid_reg != srv_addr_reg)
                  || (rstat_reg != STAT_ABSENT && rstat_reg != STAT_GOOD);

    // requested address and its pool slot
    assign req_addr  = (rstat_reg == STAT_GOOD) ? raddr_reg : caddr_reg;
    assign want_diff = {1'b0, req_addr[7:0]} - {1'b0, pool_base_reg};
    assign want_init = (req_addr[31:8] == srv_addr_reg[31:8]) && !want_diff[8]
                       && (want_diff[7:0] < 8'(POOL_SIZE));

    // expiry test on the slot read back this cycle
    assign age        = now_reg - expiry_q;
    assign live_now   = live_reg[eval_idx_reg];
    assign live_after = live_now && age[31];
    assign mine       = live_after && (owner_q == mac_reg);

    // new expiry: one adder shared by all writes
    assign expiry_new = now_reg + ((tval_reg == TYPE_REQUEST) ? LEASE_HOLD_MS : OFFER_HOLD_MS);

    // slot acted on in the update cycle
    always_comb
    begin
        priority if (tval_reg == TYPE_DISCOVER)
        begin
            act_slot = slot_hit_reg ? slot_idx_reg : free_idx_reg;
        end
        else if (tval_reg == TYPE_REQUEST)
        begin
            act_slot = wanted_idx_reg;
        end
        else
        begin
            act_slot = slot_idx_reg;
        end
    end

    assign act_addr = {srv_addr_reg[31:8], pool_base_reg + 8'(act_slot)};

    // next-state and datapath
    always_comb
    begin
        state_next       = state_reg;
        srv_addr_next    = srv_addr_reg;
        pool_base_next   = pool_base_reg;
        header_ok_next   = header_ok_reg;
        now_next         = now_reg;
        mac_next         = mac_reg;
        tstat_next       = tstat_reg;
        tval_next        = tval_reg;
        sstat_next       = sstat_reg;
        sid_next         = sid_reg;
        rstat_next       = rstat_reg;
        raddr_next       = raddr_reg;
        caddr_next       = caddr_reg;
        xid_next         = xid_reg;
        scan_idx_next    = scan_idx_reg;
        eval_vld_next    = eval_vld_reg;
        eval_idx_next    = eval_idx_reg;
        slot_hit_next    = slot_hit_reg;
        slot_idx_next    = slot_idx_reg;
        free_hit_next    = free_hit_reg;
        free_idx_next    = free_idx_reg;
        want_ok_next     = want_ok_reg;
        wanted_idx_next  = wanted_idx_reg;
        live_next        = live_reg;
        reply_valid_next = 1'b0;
        reply_kind_next  = reply_kind_reg;
        reply_xid_next   = reply_xid_reg;
        reply_mac_next   = reply_mac_reg;
        your_addr_next   = your_addr_reg;
        ram_we           = 1'b0;
        ram_waddr        = act_slot;
        ram_wdata        = {mac_reg, expiry_new};

        // configuration writes; the netmask reaches no output
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SRV_ADDR:  srv_addr_next = cfg_data;
                CFG_NETMASK:   ;
                CFG_POOL_BASE: pool_base_next = cfg_data[7:0];
                default:       ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    header_ok_next = header_ok;
                    now_next       = now_ms;
                    mac_next       = client_mac;
                    tstat_next     = type_status;
                    tval_next      = type_value;
                    sstat_next     = server_id_status;
                    sid_next       = server_id;
                    rstat_next     = requested_status;
                    raddr_next     = requested_addr;
                    caddr_next     = client_addr;
                    xid_next       = transaction_id;
                    state_next     = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (drop)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    want_ok_next    = want_init;
                    wanted_idx_next = want_diff[IDX_W-1:0];
                    scan_idx_next   = '0;
                    eval_vld_next   = 1'b0;
                    slot_hit_next   = 1'b0;
                    free_hit_next   = 1'b0;
                    state_next      = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // issue the next read while judging the previous one
                if (scan_idx_reg != CNT_W'(POOL_SIZE))
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                eval_vld_next = (scan_idx_reg != CNT_W'(POOL_SIZE));
                eval_idx_next = scan_idx_reg[IDX_W-1:0];

                if (eval_vld_reg)
                begin
                    if (live_now && !age[31])
                    begin
                        live_next[eval_idx_reg] = 1'b0;
                    end
                    if (mine)
                    begin
                        slot_hit_next = 1'b1;
                        slot_idx_next = eval_idx_reg;
                    end
                    if (!live_after && !free_hit_reg)
                    begin
                        free_hit_next = 1'b1;
                        free_idx_next = eval_idx_reg;
                    end
                    // requested slot held by another client
                    if (eval_idx_reg == wanted_idx_reg && live_after && !mine)
                    begin
                        want_ok_next = 1'b0;
                    end
                    if (eval_idx_reg == IDX_W'(POOL_SIZE - 1))
                    begin
                        state_next = S_ACT;
                    end
                end
            end

            S_ACT:
            begin
                reply_xid_next = xid_reg;
                reply_mac_next = mac_reg;
                state_next     = S_IDLE;
                priority if (tval_reg == TYPE_RELEASE)
                begin
                    if (slot_hit_reg)
                    begin
                        live_next[slot_idx_reg] = 1'b0;
                    end
                end
                else if (tval_reg == TYPE_DECLINE)
                begin
                    if (slot_hit_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {MAC_DECLINED, expiry_new};
                    end
                end
                else if (tval_reg == TYPE_DISCOVER)
                begin
                    if (slot_hit_reg || free_hit_reg)
                    begin
                        ram_we              = 1'b1;
                        live_next[act_slot] = 1'b1;
                        reply_valid_next    = 1'b1;
                        reply_kind_next     = KIND_OFFER;
                        your_addr_next      = act_addr;
                    end
                end
                else if (tval_reg == TYPE_REQUEST)
                begin
                    reply_valid_next = 1'b1;
                    if (want_ok_reg)
                    begin
                        ram_we              = 1'b1;
                        live_next[act_slot] = 1'b1;
                        reply_kind_next     = KIND_ACK;
                        your_addr_next      = act_addr;
                    end
                    else
                    begin
                        reply_kind_next = KIND_NAK;
                        your_addr_next  = '0;
                    end
                end
                else
                begin
                    // unknown message type: expiry only, no reply
                end
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            srv_addr_reg    <= SRV_ADDR_RESET;
            pool_base_reg   <= POOL_BASE_RESET;
            header_ok_reg   <= 1'b0;
            now_reg         <= '0;
            mac_reg         <= '0;
            tstat_reg       <= '0;
            tval_reg        <= '0;
            sstat_reg       <= '0;
            sid_reg         <= '0;
            rstat_reg       <= '0;
            raddr_reg       <= '0;
            caddr_reg       <= '0;
            xid_reg         <= '0;
            scan_idx_reg    <= '0;
            eval_vld_reg    <= 1'b0;
            eval_idx_reg    <= '0;
            slot_hit_reg    <= 1'b0;
            slot_idx_reg    <= '0;
            free_hit_reg    <= 1'b0;
            free_idx_reg    <= '0;
            want_ok_reg     <= 1'b0;
            wanted_idx_reg  <= '0;
            live_reg        <= '0;
            reply_valid_reg <= 1'b0;
            reply_kind_reg  <= '0;
            reply_xid_reg   <= '0;
            reply_mac_reg   <= '0;
            your_addr_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            srv_addr_reg    <= srv_addr_next;
            pool_base_reg   <= pool_base_next;
            header_ok_reg   <= header_ok_next;
            now_reg         <= now_next;
            mac_reg         <= mac_next;
            tstat_reg       <= tstat_next;
            tval_reg        <= tval_next;
            sstat_reg       <= sstat_next;
            sid_reg         <= sid_next;
            rstat_reg       <= rstat_next;
            raddr_reg       <= raddr_next;
            caddr_reg       <= caddr_next;
            xid_reg         <= xid_next;
            scan_idx_reg    <= scan_idx_next;
            eval_vld_reg    <= eval_vld_next;
            eval_idx_reg    <= eval_idx_next;
            slot_hit_reg    <= slot_hit_next;
            slot_idx_reg    <= slot_idx_next;
            free_hit_reg    <= free_hit_next;
            free_idx_reg    <= free_idx_next;
            want_ok_reg     <= want_ok_next;
            wanted_idx_reg  <= wanted_idx_next;
            live_reg        <= live_next;
            reply_valid_reg <= reply_valid_next;
            reply_kind_reg  <= reply_kind_next;
            reply_xid_reg   <= reply_xid_next;
            reply_mac_reg   <= reply_mac_next;
            your_addr_reg   <= your_addr_next;
        end
    end

    // port drive
    assign busy        = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign reply_valid = reply_valid_reg;
    assign reply_kind  = reply_kind_reg;
    assign reply_xid   = reply_xid_reg;
    assign reply_mac   = reply_mac_reg;
    assign your_addr   = your_addr_reg;

    // checks
    `DLS_ASSERT_IMP(a_reply_after_update, clk, rst_n, reply_valid_reg, $past(state_reg) == S_ACT)
    `DLS_ASSERT_IMP(a_nak_no_addr, clk, rst_n, reply_valid_reg && reply_kind_reg == KIND_NAK, your_addr_reg == 32'd0)
    `DLS_ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, start && !busy, busy)
    `DLS_ASSERT_IMP(a_live_change_in_work, clk, rst_n, !$stable(live_reg), $past(state_reg == S_SCAN || state_reg == S_ACT))

endmodule

// File: rtl/dls_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dls_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: test/lease_check_pkg.sv
// Scoreboard for the DHCP lease server bench: request and reply words, a
// lease-table predictor and the in-order reply checker. Depends on dls_pkg.
`timescale 1ns / 1ps

package lease_check_pkg;

    import dls_pkg::*;

    localparam int          POOL_SLOTS      = DEFAULT_POOL_SIZE;
    localparam logic [31:0] NETMASK_RESET   = 32'hFFFF_FF00;
    localparam logic [1:0]  STAT_BAD_LENGTH = 2'd2;
    localparam logic [7:0]  TYPE_UNKNOWN    = 8'hFF;
    localparam int          MAX_REPORTS     = 40;

    // one pre-parsed request word
    typedef struct packed {
        logic        header_ok;
        logic [31:0] now_ms;
        logic [47:0] client_mac;
        logic [1:0]  type_status;
        logic [7:0]  type_value;
        logic [1:0]  server_id_status;
        logic [31:0] server_id;
        logic [1:0]  requested_status;
        logic [31:0] requested_addr;
        logic [31:0] client_addr;
        logic [31:0] transaction_id;
    } dhcp_request_t;

    // one reply word, fields in port order
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] xid;
        logic [47:0] mac;
        logic [31:0] yaddr;
    } dhcp_reply_t;

    class lease_ledger;

        logic [31:0] srv_addr;
        logic [31:0] netmask;
        logic [7:0]  pool_base;
        logic [47:0] owner [POOL_SLOTS];
        logic [31:0] expiry [POOL_SLOTS];
        dhcp_reply_t pending [$];
        int          mismatches;
        int          offers;
        int          acks;
        int          naks;

        function new();
            srv_addr   = SRV_ADDR_RESET;
            netmask    = NETMASK_RESET;
            pool_base  = POOL_BASE_RESET;
            mismatches = 0;
            offers     = 0;
            acks       = 0;
            naks       = 0;
            for (int i = 0; i < POOL_SLOTS; i++)
            begin
                owner[i]  = '0;
                expiry[i] = '0;
            end
        endfunction

        function void write_register(logic [1:0] index, logic [31:0] data);
            case (index)
                CFG_SRV_ADDR:  srv_addr = data;
                CFG_NETMASK:   netmask = data;
                CFG_POOL_BASE: pool_base = data[7:0];
                default: ;
            endcase
        endfunction

        // Apply one accepted request to the lease table and queue its reply.
        // Returns 1 when the request got past the front checks.
        function bit take_request(dhcp_request_t rq);
            int          hit;
            int          free_idx;
            int          want;
            logic [31:0] addr;
            logic [31:0] age;
            logic [7:0]  off;
            dhcp_reply_t rp;
            // malformed requests leave no trace
            if (!rq.header_ok || rq.client_mac == '0 || rq.type_status != STAT_GOOD)
                return 1'b0;
            if (rq.server_id_status > STAT_GOOD ||
                (rq.server_id_status == STAT_GOOD && rq.server_id != srv_addr))
                return 1'b0;
            if (rq.requested_status > STAT_GOOD)
                return 1'b0;

            // expire stale leases; note client's highest slot and lowest free one
            hit      = -1;
            free_idx = -1;
            for (int i = 0; i < POOL_SLOTS; i++)
            begin
                age = rq.now_ms - expiry[i];
                if (owner[i] != '0 && age < 32'h8000_0000)
                    owner[i] = '0;
                if (owner[i] == rq.client_mac)
                    hit = i;
                if (owner[i] == '0 && free_idx < 0)
                    free_idx = i;
            end

            rp.xid   = rq.transaction_id;
            rp.mac   = rq.client_mac;
            rp.yaddr = '0;
            case (rq.type_value)
                TYPE_RELEASE, TYPE_DECLINE:
                begin
                    if (hit >= 0)
                    begin
                        if (rq.type_value == TYPE_RELEASE)
                            owner[hit] = '0;
                        else
                        begin
                            owner[hit]  = MAC_DECLINED;
                            expiry[hit] = rq.now_ms + OFFER_HOLD_MS;
                        end
                    end
                    return 1'b1;
                end
                TYPE_DISCOVER:
                begin
                    if (hit < 0)
                        hit = free_idx;
                    if (hit < 0)
                        return 1'b1;
                    rp.kind = KIND_OFFER;
                end
                TYPE_REQUEST:
                begin
                    addr = (rq.requested_status == STAT_GOOD) ? rq.requested_addr
                                                              : rq.client_addr;
                    want = int'(addr[7:0]) - int'(pool_base);
                    if (addr[31:8] != srv_addr[31:8] || want < 0 || want >= POOL_SLOTS)
                    begin
                        rp.kind = KIND_NAK;
                        hit     = -1;
                    end
                    else if (owner[want] != '0 && owner[want] != rq.client_mac)
                    begin
                        rp.kind = KIND_NAK;
                        hit     = -1;
                    end
                    else
                    begin
                        rp.kind = KIND_ACK;
                        hit     = want;
                    end
                end
                default:
                    return 1'b1;
            endcase

            // commit the slot
            if (hit >= 0)
            begin
                owner[hit]  = rq.client_mac;
                expiry[hit] = rq.now_ms + ((rp.kind == KIND_OFFER) ? OFFER_HOLD_MS
                                                                   : LEASE_HOLD_MS);
                off         = hit[7:0];
                rp.yaddr    = {srv_addr[31:8], pool_base + off};
            end
            pending.push_back(rp);
            return 1'b1;
        endfunction

        function void report_field(string name, logic [47:0] want, logic [47:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
        endfunction

        // compare one strobed reply with the oldest queued one
        function void match_reply(dhcp_reply_t got);
            dhcp_reply_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t ns: reply with none queued, expected nothing, got %h",
                             $time, got);
                return;
            end
            want = pending.pop_front();
            case (want.kind)
                KIND_OFFER: offers++;
                KIND_ACK:   acks++;
                default:    naks++;
            endcase
            if (got.kind !== want.kind)
                report_field("reply_kind", 48'(want.kind), 48'(got.kind));
            if (got.xid !== want.xid)
                report_field("reply_xid", 48'(want.xid), 48'(got.xid));
            if (got.mac !== want.mac)
                report_field("reply_mac", want.mac, got.mac);
            if (got.yaddr !== want.yaddr)
                report_field("your_addr", 48'(want.yaddr), 48'(got.yaddr));
        endfunction

    endclass

endpackage

// File: test/tb.sv
// Testbench top for dhcp_lease_server: directed and random requests under
// several register settings, checked against lease_check_pkg's predictor.
// Depends on dls_pkg, lease_check_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

    import dls_pkg::*;
    import lease_check_pkg::*;

    localparam int NUM_CLIENTS        = 12;
    localparam int NUM_SETTINGS       = 5;
    localparam int RANDOM_PER_SETTING = 300;
    localparam int SETTLE_CYCLES      = POOL_SLOTS + 8;
    localparam int WATCHDOG_LIMIT     = 4000;

    logic        clk;
    logic        rst_n            = 1'b0;
    logic        start            = 1'b0;
    logic        busy;
    logic        header_ok        = 1'b0;
    logic [31:0] now_ms           = '0;
    logic [47:0] client_mac       = '0;
    logic [1:0]  type_status      = '0;
    logic [7:0]  type_value       = '0;
    logic [1:0]  server_id_status = '0;
    logic [31:0] server_id        = '0;
    logic [1:0]  requested_status = '0;
    logic [31:0] requested_addr   = '0;
    logic [31:0] client_addr      = '0;
    logic [31:0] transaction_id   = '0;
    logic        reply_valid;
    logic [1:0]  reply_kind;
    logic [31:0] reply_xid;
    logic [47:0] reply_mac;
    logic [31:0] your_addr;
    logic        cfg_valid        = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index        = '0;
    logic [31:0] cfg_data         = '0;

    lease_ledger ledger;
    logic [31:0] wall_ms;
    logic [47:0] clients [NUM_CLIENTS];
    int          sent_total   = 0;
    int          passed_total = 0;
    int          quiet_cycles = 0;

    dhcp_lease_server #(
        .POOL_SIZE(POOL_SLOTS)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .header_ok        (header_ok),
        .now_ms           (now_ms),
        .client_mac       (client_mac),
        .type_status      (type_status),
        .type_value       (type_value),
        .server_id_status (server_id_status),
        .server_id        (server_id),
        .requested_status (requested_status),
        .requested_addr   (requested_addr),
        .client_addr      (client_addr),
        .transaction_id   (transaction_id),
        .reply_valid      (reply_valid),
        .reply_kind       (reply_kind),
        .reply_xid        (reply_xid),
        .reply_mac        (reply_mac),
        .your_addr        (your_addr),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // reply monitor: every strobe is one word
    always @(posedge clk)
    begin
        if (rst_n && reply_valid === 1'b1)
            ledger.match_reply({reply_kind, reply_xid, reply_mac, your_addr});
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || reply_valid === 1'b1 ||
            (cfg_valid && cfg_ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: watchdog expired, nothing moved for %0d cycles",
                     $time, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [47:0] random_mac();
        return 48'({$urandom, $urandom}) | 48'h1;
    endfunction

    // mostly back to back or short gaps, now and then a long one
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pool_address(int slot);
        logic [7:0] octet;
        octet = ledger.pool_base + 8'(slot);
        return {ledger.srv_addr[31:8], octet};
    endfunction

    function automatic dhcp_request_t plain_request(logic [47:0] mac, logic [7:0] code);
        dhcp_request_t rq;
        rq.header_ok        = 1'b1;
        rq.now_ms           = wall_ms;
        rq.client_mac       = mac;
        rq.type_status      = STAT_GOOD;
        rq.type_value       = code;
        rq.server_id_status = STAT_ABSENT;
        rq.server_id        = $urandom;
        rq.requested_status = STAT_ABSENT;
        rq.requested_addr   = $urandom;
        rq.client_addr      = $urandom;
        rq.transaction_id   = $urandom;
        return rq;
    endfunction

    // well-formed traffic from a small client set, with some noise mixed in
    function automatic dhcp_request_t random_request();
        dhcp_request_t rq;
        int            roll;
        int            offset;
        logic [31:0]   pool_addr;
        logic [31:0]   other;
        roll      = $urandom_range(0, 99);
        offset    = $urandom_range(0, POOL_SLOTS + 3) - 2;
        pool_addr = pool_address(offset);
        if ($urandom_range(0, 19) == 0)
            pool_addr = $urandom;
        other = $urandom;
        rq    = plain_request(clients[$urandom_range(0, NUM_CLIENTS - 1)], TYPE_DISCOVER);
        if (roll < 35)
            rq.type_value = TYPE_DISCOVER;
        else if (roll < 75)
            rq.type_value = TYPE_REQUEST;
        else if (roll < 83)
            rq.type_value = TYPE_DECLINE;
        else if (roll < 95)
            rq.type_value = TYPE_RELEASE;
        else
            rq.type_value = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1)
        begin
            rq.server_id_status = STAT_GOOD;
            rq.server_id        = ledger.srv_addr;
        end
        if ($urandom_range(0, 1) == 1)
        begin
            rq.requested_status = STAT_GOOD;
            rq.requested_addr   = pool_addr;
            rq.client_addr      = other;
        end
        else
        begin
            rq.requested_addr = other;
            rq.client_addr    = pool_addr;
        end

        // noise: broken headers, bad options, random types, macs and times
        if ($urandom_range(0, 7) == 0)
        begin
            rq.header_ok        = 1'($urandom_range(0, 1));
            rq.type_status      = 2'($urandom_range(0, 2));
            rq.type_value       = 8'($urandom_range(0, 255));
            rq.server_id_status = 2'($urandom_range(0, 2));
            rq.requested_status = 2'($urandom_range(0, 2));
            if ($urandom_range(0, 1) == 1)
                rq.server_id = $urandom;
            if ($urandom_range(0, 3) == 0)
                rq.client_mac = random_mac();
            if ($urandom_range(0, 15) == 0)
                rq.client_mac = '0;
            if ($urandom_range(0, 3) == 0)
                rq.now_ms = $urandom;
        end
        return rq;
    endfunction

    // present one request and hold it until the block takes it
    task automatic issue_request(input dhcp_request_t rq, input int gap, output bit acted);
        start            <= 1'b1;
        header_ok        <= rq.header_ok;
        now_ms           <= rq.now_ms;
        client_mac       <= rq.client_mac;
        type_status      <= rq.type_status;
        type_value       <= rq.type_value;
        server_id_status <= rq.server_id_status;
        server_id        <= rq.server_id;
        requested_status <= rq.requested_status;
        requested_addr   <= rq.requested_addr;
        client_addr      <= rq.client_addr;
        transaction_id   <= rq.transaction_id;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sent_total++;
        acted = ledger.take_request(rq);
        if (acted)
            passed_total++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send(input dhcp_request_t rq);
        bit acted;
        rq.now_ms = wall_ms;
        issue_request(rq, idle_gap(), acted);
        wall_ms = wall_ms + $urandom_range(1, 50);
    endtask

    // hold off new requests until every queued reply has come back
    task automatic drain_replies();
        start <= 1'b0;
        do
            @(posedge clk);
        while (ledger.pending.size() != 0);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        ledger.write_register(index, data);
    endtask

    // reprogram all registers while the block is idle
    task automatic apply_setting(input int n);
        logic [31:0] ip;
        logic [31:0] mask;
        logic [31:0] base_word;
        base_word = $urandom;
        case (n)
            1:
            begin
                ip             = 32'h0A00_0001;
                mask           = 32'hFFFF_0000;
                base_word[7:0] = 8'd0;
            end
            2:
            begin
                ip             = 32'hFFFF_FFFF;
                mask           = 32'h0000_0000;
                base_word[7:0] = 8'd255;
            end
            3:
            begin
                ip             = 32'h0000_0000;
                mask           = 32'hFFFF_FFFF;
                base_word[7:0] = 8'd250;
            end
            default:
            begin
                ip   = $urandom;
                mask = $urandom;
            end
        endcase
        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(CFG_SRV_ADDR, ip);
        write_register(CFG_NETMASK, mask);
        write_register(CFG_POOL_BASE, base_word);
        cfg_valid <= 1'b0;
        wall_ms = $urandom;
        for (int i = 3; i < NUM_CLIENTS; i++)
            clients[i] = random_mac();
    endtask

    task automatic run_directed();
        dhcp_request_t rq;
        logic [47:0]   mac_a;
        logic [47:0]   mac_b;
        mac_a   = 48'h0200_0000_00A1;
        mac_b   = 48'h0200_0000_00B2;
        wall_ms = 32'hFFFF_F000;

        // front checks drop these
        rq = plain_request(mac_a, TYPE_DISCOVER);
        rq.header_ok = 1'b0;
        send(rq);
        rq = plain_request('0, TYPE_DISCOVER);
        send(rq);
        rq = plain_request(mac_a, TYPE_DISCOVER);
        rq.type_status = STAT_ABSENT;
        send(rq);
        rq.type_status = STAT_BAD_LENGTH;
        send(rq);
        rq = plain_request(mac_a, TYPE_DISCOVER);
        rq.server_id_status = STAT_BAD_LENGTH;
        send(rq);
        rq.server_id_status = STAT_GOOD;
        rq.server_id        = ledger.srv_addr ^ 32'h1;
        send(rq);
        rq = plain_request(mac_a, TYPE_DISCOVER);
        rq.requested_status = STAT_BAD_LENGTH;
        send(rq);

        // offer then ack of the first slot, server id present
        rq = plain_request(mac_a, TYPE_DISCOVER);
        rq.server_id_status = STAT_GOOD;
        rq.server_id        = ledger.srv_addr;
        send(rq);
        rq.type_value       = TYPE_REQUEST;
        rq.requested_status = STAT_GOOD;
        rq.requested_addr   = pool_address(0);
        send(rq);

        // naks: taken slot, foreign subnet, below the pool
        rq = plain_request(mac_b, TYPE_REQUEST);
        rq.requested_status = STAT_GOOD;
        rq.requested_addr   = pool_address(0);
        send(rq);
        rq.requested_addr = pool_address(1) ^ 32'h0001_0000;
        send(rq);
        rq.requested_addr = pool_address(-1);
        send(rq);

        // renew through ciaddr, then a second lease for the same client
        rq = plain_request(mac_a, TYPE_REQUEST);
        rq.client_addr = pool_address(0);
        send(rq);
        rq.client_addr = pool_address(3);
        send(rq);
        // client holds two slots: the higher one is used, then released
        send(plain_request(mac_a, TYPE_DISCOVER));
        send(plain_request(mac_a, TYPE_RELEASE));
        // decline parks slot 0; an all-ones client then matches it
        send(plain_request(mac_a, TYPE_DECLINE));
        rq = plain_request(MAC_DECLINED, TYPE_DISCOVER);
        rq.transaction_id = '1;
        send(rq);

        // release from an unknown client, unknown message type
        send(plain_request(mac_b, TYPE_RELEASE));
        send(plain_request(mac_b, TYPE_UNKNOWN));

        // fill the pool; the last discover finds no slot
        for (int k = 0; k < POOL_SLOTS; k++)
            send(plain_request(48'h0200_0000_1000 + 48'(k), TYPE_DISCOVER));

        // past the offer hold, across the wrap of the clock
        wall_ms = wall_ms + OFFER_HOLD_MS + 32'd1;
        send(plain_request(mac_b, TYPE_DISCOVER));
    endtask

    task automatic run_random(input int quota);
        dhcp_request_t rq;
        int            done;
        int            n;
        int            roll;
        int            gap;
        bit            acted;
        done = 0;
        n    = 0;
        while (done < quota)
        begin
            // clock steps: mostly short, some past the offer hold, rarely a lease
            roll = $urandom_range(0, 99);
            if (roll < 75)
                wall_ms = wall_ms + $urandom_range(0, 3000);
            else if (roll < 94)
                wall_ms = wall_ms + $urandom_range(3000, 70000);
            else if (roll < 99)
                wall_ms = wall_ms + $urandom_range(70000, 2000000);
            else
                wall_ms = wall_ms + LEASE_HOLD_MS + $urandom_range(0, 1000);
            rq  = random_request();
            gap = ((n % 120) < 30) ? 0 : idle_gap();
            issue_request(rq, gap, acted);
            n++;
            if (acted)
                done++;
            if ((acted && done == quota / 2) || $urandom_range(0, 149) == 0)
                drain_replies();
        end
    endtask

    initial
    begin
        ledger = new();
        clients[0] = MAC_DECLINED;
        clients[1] = 48'h0000_0000_0001;
        clients[2] = 48'h8000_0000_0000;
        for (int i = 3; i < NUM_CLIENTS; i++)
            clients[i] = random_mac();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values first, then the other settings
        run_directed();
        run_random(RANDOM_PER_SETTING);
        for (int s = 1; s < NUM_SETTINGS; s++)
        begin
            apply_setting(s);
            run_random(RANDOM_PER_SETTING);
        end

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Summary: %0d requests sent, %0d past the header checks, %0d settings",
                 sent_total, passed_total, NUM_SETTINGS);
        $display("Summary: %0d offers, %0d acks, %0d naks checked, %0d mismatches",
                 ledger.offers, ledger.acks, ledger.naks, ledger.mismatches);
        if (ledger.mismatches == 0 && ledger.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/dls_pkg.sv
rtl/dls_ram.sv
rtl/dhcp_lease_server.sv
test/lease_check_pkg.sv
test/tb.sv
